@@ src/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define KCLP_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");

// Check that an antecedent implies a consequent in the following cycle.
`define KCLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ src/kclp_pkg.sv @@
package kclp_pkg;

    localparam int unsigned NUM_KEYS_DEF = 2;

    localparam int unsigned CODE_W   = 10;
    localparam int unsigned TYPE_W   = 5;
    localparam int unsigned VALUE_W  = 2;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 104;

    localparam logic [TYPE_W-1:0]  KEY_EVENT_TYPE = TYPE_W'(1);
    localparam logic [VALUE_W-1:0] VAL_RELEASED   = VALUE_W'(0);

    localparam logic [CODE_W-1:0] FIRST_CODE_RST  = CODE_W'(59);
    localparam logic [CODE_W-1:0] SECOND_CODE_RST = CODE_W'(116);
    localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_CODE  = 2'd0,
        CFG_SECOND_CODE = 2'd1,
        CFG_THRESHOLD   = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2,
        EV_READ  = 2'd3
    } t_ev;

    typedef struct packed {
        logic               pressed;
        t_ev                pending;
        logic [STAMP_W-1:0] press_stamp;
        logic [STAMP_W-1:0] release_stamp;
        logic [STAMP_W-1:0] event_stamp;
    } t_key_entry;

    typedef struct packed {
        logic       en;
        t_key_entry data;
    } t_wr_req;

endpackage

@@ src/kclp_state_mem.sv @@
module kclp_state_mem
    import kclp_pkg::*;
#(
    parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
    parameter int unsigned KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [KEY_W-1:0] i_rd_addr,
    output t_key_entry       o_rd_data,
    input  t_wr_req          i_wr,
    input  logic [KEY_W-1:0] i_wr_addr
);

    t_key_entry            r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_vld;
    t_key_entry            r_rd_data;

    // Entry contents: no reset, valid bits stand in for it.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read; forward a write to the same entry in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else if (r_vld[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/kclp_key_update.sv @@
module kclp_key_update
    import kclp_pkg::*;
(
    input  t_key_entry         i_cur,
    input  logic               i_is_read,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [STAMP_W-1:0] i_now,
    input  logic [THR_W-1:0]   i_threshold,
    output t_key_entry         o_next
);

    logic [STAMP_W-1:0] elapsed;
    logic               held;
    logic               long_due;

    assign elapsed  = i_now - i_cur.press_stamp;
    assign held     = (i_value != VAL_RELEASED);
    assign long_due = (elapsed >= STAMP_W'(i_threshold));

    always_comb begin
        o_next = i_cur;
        if (i_is_read) begin
            // Acknowledge any pending event.
            if (i_cur.pending != EV_NONE) begin
                o_next.pending = EV_READ;
            end
        end else if (!i_cur.pressed) begin
            if (held) begin
                o_next.pressed     = 1'b1;
                o_next.pending     = EV_NONE;
                o_next.press_stamp = i_now;
            end
        end else if (held) begin
            if ((i_cur.pending == EV_NONE) && long_due) begin
                o_next.pending     = EV_LONG;
                o_next.event_stamp = i_now;
            end
        end else begin
            o_next.pressed       = 1'b0;
            o_next.release_stamp = i_now;
            if (i_cur.pending == EV_NONE) begin
                o_next.pending     = EV_CLICK;
                o_next.event_stamp = i_now;
            end
        end
    end

endmodule

@@ src/key_click_long_press_detector.sv @@
// A read beat passes stage one, then the output register, before it turns
// valid on the master side. Key events update the key table in the cycle
// after acceptance, no beat. Throughput: one beat per cycle; the slave side
// stalls only while a read in stage one waits behind an untaken output beat.
// Reset: clears control state and the key table's valid bits, and restores
// the register defaults (key codes 59 and 116, threshold 1000 ms).
`include "assert_macros.svh"

module key_click_long_press_detector
    import kclp_pkg::*;
#(
    parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // event_type[4:0], event_code[14:5], event_value[16:15],
    // now_ms[48:17], key_index[50:49], zero fill [55:51]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic                   s_axis_tuser,
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // is_pressed[0], event_kind[2:1], press_time[34:3],
    // release_time[66:35], event_time[98:67], zero fill [103:99]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // bad_index[0]
    output logic                   m_axis_tuser
);

    localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers; writes are always taken.
    // ---------------------------------------------------------------
    logic [CODE_W-1:0] r_first_code;
    logic [CODE_W-1:0] r_second_code;
    logic [THR_W-1:0]  r_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code  <= FIRST_CODE_RST;
            r_second_code <= SECOND_CODE_RST;
            r_threshold   <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FIRST_CODE:  r_first_code  <= i_cfg_data[CODE_W-1:0];
                CFG_SECOND_CODE: r_second_code <= i_cfg_data[CODE_W-1:0];
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THR_W-1:0];
                CFG_UNUSED:      ;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Beat unpacking and slot selection at acceptance.
    // ---------------------------------------------------------------
    logic               in_op;
    logic [TYPE_W-1:0]  in_type;
    logic [CODE_W-1:0]  in_code;
    logic [VALUE_W-1:0] in_value;
    logic [STAMP_W-1:0] in_now;
    logic [IDX_W-1:0]   in_idx;

    assign in_op    = s_axis_tuser;
    assign in_type  = s_axis_tdata[4:0];
    assign in_code  = s_axis_tdata[14:5];
    assign in_value = s_axis_tdata[16:15];
    assign in_now   = s_axis_tdata[48:17];
    assign in_idx   = s_axis_tdata[50:49];

    logic             hit_first;
    logic             hit_second;
    logic             ev_match;
    logic             idx_bad;
    logic             in_acc;
    logic             needs_stage;
    logic             rd_en;
    logic [KEY_W-1:0] acc_slot;

    // Slot zero wins when both codes match.
    assign hit_first  = (in_code == r_first_code);
    assign hit_second = (NUM_KEYS > 1) && (in_code == r_second_code);
    assign ev_match   = !in_op && (in_type == KEY_EVENT_TYPE) && (hit_first || hit_second);
    assign idx_bad    = (in_idx >= IDX_W'(NUM_KEYS));

    always_comb begin
        if (in_op) begin
            acc_slot = in_idx[KEY_W-1:0];
        end else if (hit_first) begin
            acc_slot = '0;
        end else begin
            acc_slot = KEY_W'(1);
        end
    end

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    // Drop unmatched and non-key events right here.
    assign needs_stage = in_op || ev_match;
    assign rd_en       = in_acc && (ev_match || (in_op && !idx_bad));

    // ---------------------------------------------------------------
    // Stage one: entry read back, update and write back.
    // ---------------------------------------------------------------
    logic               r_s1_vld;
    logic               r_s1_op;
    logic               r_s1_bad;
    logic [VALUE_W-1:0] r_s1_value;
    logic [STAMP_W-1:0] r_s1_now;
    logic [KEY_W-1:0]   r_s1_slot;

    logic       s1_go;
    t_key_entry cur_entry;
    t_key_entry next_entry;
    t_wr_req    mem_wr;

    logic                   r_out_vld;
    logic                   r_out_bad;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Advance unless a read result would overrun a held output beat.
    assign s1_go         = r_s1_vld && (!r_s1_op || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= in_acc && needs_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= in_op;
            r_s1_bad   <= in_op && idx_bad;
            r_s1_value <= in_value;
            r_s1_now   <= in_now;
            r_s1_slot  <= acc_slot;
        end
    end

    kclp_state_mem #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_W    (KEY_W)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (acc_slot),
        .o_rd_data (cur_entry),
        .i_wr      (mem_wr),
        .i_wr_addr (r_s1_slot)
    );

    kclp_key_update u_key_update (
        .i_cur       (cur_entry),
        .i_is_read   (r_s1_op),
        .i_value     (r_s1_value),
        .i_now       (r_s1_now),
        .i_threshold (r_threshold),
        .o_next      (next_entry)
    );

    // Bad slot reads leave the table alone.
    assign mem_wr.en   = s1_go && !r_s1_bad;
    assign mem_wr.data = next_entry;

    // ---------------------------------------------------------------
    // Output register: holds a read result until the sink takes it.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && r_s1_op) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_op) begin
            r_out_bad <= r_s1_bad;
            if (r_s1_bad) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {5'b0, cur_entry.event_stamp, cur_entry.release_stamp,
                               cur_entry.press_stamp, cur_entry.pending, cur_entry.pressed};
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `KCLP_ASSERT(a_no_write_on_stall, i_clk, i_rst_n, !(r_s1_vld && !s1_go) || !mem_wr.en)
    `KCLP_ASSERT(a_bad_beat_zero, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == '0))
    `KCLP_ASSERT(a_no_click_while_held, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tdata[0]) || (m_axis_tdata[2:1] != EV_CLICK))
    `KCLP_ASSERT_NEXT(a_read_reaches_out, i_clk, i_rst_n,
        s1_go && r_s1_op, m_axis_tvalid)

endmodule
